[rtl/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine: item kinds,
// control characters, the queued command and the result record.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // field widths of the request and response items
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int NEW_COL_W   = 7;
   localparam int NEW_ROW_W   = 5;
   localparam int CUR_COL_W   = 7;
   localparam int CUR_ROW_W   = 5;
   localparam int LINEAR_W    = 11;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_PAD_W   = RSP_DATA_W - (CUR_COL_W + CUR_ROW_W + LINEAR_W + 1 +
                                              LINEAR_W + CELL_W + 1);
   localparam int REQ_PAD_W   = REQ_DATA_W - (CHAR_W + NEW_COL_W + NEW_ROW_W);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

   // attribute after reset (white on black)
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   // command queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // decoded operation
   typedef enum logic [2:0] {
      OP_PUT,
      OP_CR,
      OP_LF,
      OP_TAB,
      OP_BS,
      OP_SET,
      OP_CLEAR,
      OP_NOP
   } op_type;

   // command handed from front to back
   typedef struct packed {
      op_type                 op;
      logic [CHAR_W-1:0]      ch;
      logic [NEW_COL_W-1:0]   ncol;
      logic [NEW_ROW_W-1:0]   nrow;
   } cmd_type;

   // result record
   typedef struct packed {
      logic                   scrolled;
      logic [CELL_W-1:0]      cell_value;
      logic [LINEAR_W-1:0]    cell_index;
      logic                   cell_written;
      logic [LINEAR_W-1:0]    cursor_linear;
      logic [CUR_ROW_W-1:0]   cursor_row;
      logic [CUR_COL_W-1:0]   cursor_col;
   } rsp_type;

   // back end status seen by the front end
   typedef struct packed {
      logic init_done;
   } bk_status_type;

   // back end sequencer
   typedef enum logic [1:0] {
      BK_RUN,
      BK_COPY,
      BK_FILL
   } bk_state_type;

endpackage

[rtl/tcce_queue.sv]
// ----------------------------------------------------------------------------
// tcce_queue
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module tcce_queue
   import tcce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/tcce_front.sv]
// ----------------------------------------------------------------------------
// tcce_front
// Accepts request transfers and decodes them into console operations.
// ----------------------------------------------------------------------------
module tcce_front
   import tcce_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  queue_full,
   input  bk_status_type         status,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic [CHAR_W-1:0]    ch;
   logic [NEW_COL_W-1:0] ncol;
   logic [NEW_ROW_W-1:0] nrow;
   logic [REQ_PAD_W-1:0] pad_bits;

   assign {pad_bits, nrow, ncol, ch} = req_tdata;

   // hold off until the screen has been blanked after reset
   assign req_tready = !queue_full && status.init_done;
   assign push       = req_tvalid && req_tready;

   // classify the item
   always_comb begin
      push_cmd.ch   = ch;
      push_cmd.ncol = ncol;
      push_cmd.nrow = nrow;
      case (req_tuser)
         KIND_PUT: begin
            case (ch)
               CH_CR:   push_cmd.op = OP_CR;
               CH_LF:   push_cmd.op = OP_LF;
               CH_TAB:  push_cmd.op = OP_TAB;
               CH_BS:   push_cmd.op = OP_BS;
               default: push_cmd.op = OP_PUT;
            endcase
         end
         KIND_SET:   push_cmd.op = OP_SET;
         KIND_CLEAR: push_cmd.op = OP_CLEAR;
         default:    push_cmd.op = OP_NOP;
      endcase
   end

endmodule

[rtl/tcce_back.sv]
// ----------------------------------------------------------------------------
// tcce_back
// Executes console operations: cursor update, cell write, result register,
// and the screen memory sweeps for scroll, clear and post-reset blanking.
// ----------------------------------------------------------------------------
module tcce_back
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ATTR_W-1:0] attr,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp,
   output bk_status_type     status
);

   localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_COUNT  = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);
   localparam int COL_NEXT_W  = $clog2(SCREEN_WIDTH + TAB_STOP + 1);
   localparam int ROW_NEXT_W  = $clog2(SCREEN_HEIGHT + 1);
   localparam int LIN_CALC_W  = (ADDR_W > LINEAR_W) ? ADDR_W : LINEAR_W;
   localparam int TAB_ENTRIES = 2 ** CUR_COL_W;

   // linear position of a cell
   function automatic logic [LIN_CALC_W-1:0] lin_of(input logic [CUR_ROW_W-1:0] row,
                                                   input logic [CUR_COL_W-1:0] col);
      lin_of = LIN_CALC_W'(row) * LIN_CALC_W'(SCREEN_WIDTH) + LIN_CALC_W'(col);
   endfunction

   // next tab stop for every column
   logic [COL_NEXT_W-1:0] tab_next [TAB_ENTRIES];
   for (genvar g = 0; g < TAB_ENTRIES; g++) begin : g_tab
      assign tab_next[g] = COL_NEXT_W'(((g / TAB_STOP) + 1) * TAB_STOP);
   end

   // screen memory
   logic [CELL_W-1:0]   screen_mem [CELL_COUNT];
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [CELL_W-1:0]   mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [CELL_W-1:0]   rd_data_ff;

   // control and payload registers
   bk_state_type         state_ff, state_in;
   logic [SWEEP_W-1:0]   sweep_ff, sweep_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0]    rd_dst_ff, rd_dst_in;
   logic [CELL_W-1:0]    fill_val_ff, fill_val_in;
   logic                 init_done_ff, init_done_in;
   logic [CUR_COL_W-1:0] col_ff, col_in;
   logic [CUR_ROW_W-1:0] row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // execute-stage values
   logic [COL_NEXT_W-1:0] col_n;
   logic [ROW_NEXT_W-1:0] row_n;
   logic                  wrote;
   logic [CUR_COL_W-1:0]  wcol;
   logic [CELL_W-1:0]     wval;
   logic                  scroll_hit;
   logic [LIN_CALC_W-1:0] widx;
   logic [LIN_CALC_W-1:0] lin_final;
   logic [CUR_COL_W-1:0]  col_final;
   logic [CUR_ROW_W-1:0]  row_final;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp              = rsp_ff;
   assign status.init_done = init_done_ff;

   // cursor update and cell write for one operation
   always_comb begin
      col_n      = COL_NEXT_W'(col_ff);
      row_n      = ROW_NEXT_W'(row_ff);
      wrote      = 1'b0;
      wcol       = col_ff;
      wval       = '0;
      scroll_hit = 1'b0;
      case (cmd.op)
         OP_PUT: begin
            wrote = 1'b1;
            wval  = {attr, cmd.ch};
            col_n = COL_NEXT_W'(col_ff) + 1'b1;
         end
         OP_CR: col_n = '0;
         OP_LF: begin
            col_n = '0;
            row_n = ROW_NEXT_W'(row_ff) + 1'b1;
         end
         OP_TAB: col_n = tab_next[col_ff];
         OP_BS: begin
            // backspace at the left edge does nothing
            if (col_ff != '0) begin
               wrote = 1'b1;
               wcol  = col_ff - 1'b1;
               col_n = COL_NEXT_W'(col_ff) - 1'b1;
               wval  = {attr, CH_BLANK};
            end
         end
         OP_SET: begin
            if (int'(cmd.ncol) < SCREEN_WIDTH) begin
               col_n = COL_NEXT_W'(cmd.ncol);
            end
            if (int'(cmd.nrow) < SCREEN_HEIGHT) begin
               row_n = ROW_NEXT_W'(cmd.nrow);
            end
         end
         OP_CLEAR: begin
            col_n = '0;
            row_n = '0;
         end
         default: ;
      endcase
      // line wrap
      if (col_n >= COL_NEXT_W'(SCREEN_WIDTH)) begin
         col_n = '0;
         row_n = row_n + 1'b1;
      end
      // scroll at the bottom
      if (row_n >= ROW_NEXT_W'(SCREEN_HEIGHT)) begin
         row_n      = ROW_NEXT_W'(SCREEN_HEIGHT - 1);
         scroll_hit = 1'b1;
      end
   end

   assign col_final = CUR_COL_W'(col_n);
   assign row_final = CUR_ROW_W'(row_n);
   assign widx      = lin_of(row_ff, wcol);
   assign lin_final = lin_of(row_final, col_final);

   // sequencer: execute, scroll copy, blank fill
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      rd_pend_in   = 1'b0;
      rd_dst_in    = rd_dst_ff;
      fill_val_in  = fill_val_ff;
      init_done_in = init_done_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      cmd_pop      = 1'b0;

      // result transfer frees the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         BK_RUN: begin
            if (cmd_valid && (!rsp_valid_ff || rsp_ready)) begin
               cmd_pop      = 1'b1;
               col_in       = col_final;
               row_in       = row_final;
               rsp_valid_in = 1'b1;
               rsp_in.cursor_col    = col_final;
               rsp_in.cursor_row    = row_final;
               rsp_in.cursor_linear = lin_final[LINEAR_W-1:0];
               rsp_in.cell_written  = wrote;
               rsp_in.cell_index    = wrote ? widx[LINEAR_W-1:0] : '0;
               rsp_in.cell_value    = wrote ? wval : '0;
               rsp_in.scrolled      = scroll_hit || (cmd.op == OP_CLEAR);
               if (wrote) begin
                  mem_we    = 1'b1;
                  mem_waddr = widx[ADDR_W-1:0];
                  mem_wdata = wval;
               end
               if (cmd.op == OP_CLEAR) begin
                  state_in    = BK_FILL;
                  sweep_in    = '0;
                  fill_val_in = {attr, CH_BLANK};
               end else if (scroll_hit) begin
                  state_in    = BK_COPY;
                  sweep_in    = '0;
                  fill_val_in = {attr, CH_BLANK};
               end
            end
         end
         BK_COPY: begin
            // write back the cell read in the previous cycle
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_dst_ff;
               mem_wdata = rd_data_ff;
            end
            if (sweep_ff < SWEEP_W'(COPY_COUNT)) begin
               mem_raddr  = ADDR_W'(sweep_ff + SWEEP_W'(SCREEN_WIDTH));
               rd_pend_in = 1'b1;
               rd_dst_in  = sweep_ff[ADDR_W-1:0];
               sweep_in   = sweep_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = BK_FILL;
            end
         end
         BK_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff[ADDR_W-1:0];
            mem_wdata = fill_val_ff;
            if (sweep_ff == SWEEP_W'(CELL_COUNT - 1)) begin
               state_in     = BK_RUN;
               sweep_in     = '0;
               init_done_in = 1'b1;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: state_in = BK_RUN;
      endcase
   end

   // control registers; reset starts the blanking sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FILL;
         sweep_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         fill_val_ff  <= {RESET_ATTR, CH_BLANK};
         init_done_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rd_pend_ff   <= rd_pend_in;
         fill_val_ff  <= fill_val_in;
         init_done_ff <= init_done_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      rd_dst_ff <= rd_dst_in;
   end

   // screen memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

endmodule

[rtl/text_console_cursor_engine.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text screen of 16-bit cells with a cursor; puts characters, sets the
// cursor, clears, and scrolls, reporting the cursor and any written cell.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   req_     in         req_tvalid/req_tready   tdata: char, col, row; tuser: kind
//   rsp_     out        rsp_tvalid/rsp_tready   tdata: cursor, written cell, scroll
//   csr_     in         csr_valid/csr_ready     csr_data: attribute byte
//
// An ordinary item is decoded and written into the queue at its request
// transfer, and executed by the back end when no sweep runs and the result
// register is free or being read; the result is then registered there.
// A scroll adds a memory sweep that moves every row up by one and blanks
// the bottom row, a clear one that blanks every cell, both going cell by
// cell through the single write port of the screen memory; the result is
// shown meanwhile. After reset the screen is blanked before any request is
// taken; the queue lets requests land while the back end waits on the
// response side.
//
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25,
   parameter int TAB_STOP      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_code, new_col, new_row
   input  logic [KIND_W-1:0]     req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cursor_col, cursor_row, cursor_linear, cell_written, cell_index,
   // cell_value, scrolled
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ATTR_W-1:0]     csr_data
);

   logic [ATTR_W-1:0] attr_ff;
   logic              q_full;
   logic              q_push;
   cmd_type           q_push_cmd;
   logic              q_pop;
   logic              q_valid;
   cmd_type           q_cmd;
   rsp_type           rsp;
   bk_status_type     status;

   // attribute register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   // decode
   tcce_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_full),
      .status     (status),
      .push       (q_push),
      .push_cmd   (q_push_cmd)
   );

   // command queue
   tcce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // execute
   tcce_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STOP      (TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp),
      .status    (status)
   );

   // response packing, first field in the low bits
   assign rsp_tdata = {RSP_PAD_W'(0), rsp.scrolled, rsp.cell_value, rsp.cell_index,
                       rsp.cell_written, rsp.cursor_linear, rsp.cursor_row,
                       rsp.cursor_col};

endmodule
